// ===== src/fspa_pkg.sv =====
// shared constants, types and helpers for the fixed slot pool allocator
// no dependencies; imported by every module of the block
package fspa_pkg;

   localparam int MAX_BUCKETS      = 16;
   localparam int MAX_BUCKET_SLOTS = 64;
   localparam int MAX_ALIGN        = 16;
   localparam int STACK_DEPTH      = 1024;
   localparam int MIN_SLOT_BYTES   = 8;

   localparam int STACK_AW  = $clog2(STACK_DEPTH);
   localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int BKT_W     = $clog2(MAX_BUCKETS + 1);
   localparam int SLOT_W    = $clog2(MAX_BUCKET_SLOTS + 1);
   localparam int ALIGN_LOG = $clog2(MAX_ALIGN);
   localparam int HANDLE_W  = 10;
   localparam int SIZE_W    = 16;
   localparam int RALIGN_W  = 13;
   localparam int MUL_W     = (BKT_W + SLOT_W + 1 > HANDLE_W) ? BKT_W + SLOT_W + 1 : HANDLE_W;

   localparam int ISIZE_W   = 13;
   localparam int IALIGN_W  = 5;
   localparam int BSLOTS_W  = 7;

   localparam int APB_AW    = 4;
   localparam int APB_DW    = 32;

   localparam logic [APB_AW-3:0] REG_ITEM_SIZE    = 2'd0;
   localparam logic [APB_AW-3:0] REG_ITEM_ALIGN   = 2'd1;
   localparam logic [APB_AW-3:0] REG_BUCKET_SLOTS = 2'd2;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_REJECT     = 2'd1,
      ST_NO_BUCKET  = 2'd2,
      ST_STACK_FULL = 2'd3
   } status_type;

   typedef struct packed {
      logic [ISIZE_W-1:0]  item_size;
      logic [IALIGN_W-1:0] item_align;
      logic [BSLOTS_W-1:0] bucket_slots;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic capture;
   } ctrl_cmd_type;

   typedef struct packed {
      logic pop;
   } dp_status_type;

   // largest power of two up to MAX_ALIGN dividing the size
   function automatic logic [RALIGN_W-1:0] derived_align(input logic [ISIZE_W-1:0] size);
      logic [RALIGN_W-1:0] a;
      logic [ISIZE_W-1:0]  mask;
      a = RALIGN_W'(1);
      for (int k = 1; k <= ALIGN_LOG; k++) begin
         mask = ISIZE_W'((1 << k) - 1);
         if ((size & mask) == '0) begin
            a = RALIGN_W'(1 << k);
         end
      end
      return a;
   endfunction

   // bucket slot count clamped to 1..MAX_BUCKET_SLOTS
   function automatic logic [SLOT_W-1:0] clamp_slots(input logic [BSLOTS_W-1:0] bs);
      logic [SLOT_W-1:0] s;
      if (bs == '0) begin
         s = SLOT_W'(1);
      end else if (int'(bs) > MAX_BUCKET_SLOTS) begin
         s = SLOT_W'(MAX_BUCKET_SLOTS);
      end else begin
         s = SLOT_W'(bs);
      end
      return s;
   endfunction

endpackage

// ===== src/fspa_csr.sv =====
// configuration registers behind the apb-style port
// depends on fspa_pkg
module fspa_csr
   import fspa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type          cfg_ff;
   logic             wr_en;
   logic [APB_AW-3:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[APB_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.item_size    <= ISIZE_W'(8);
         cfg_ff.item_align   <= '0;
         cfg_ff.bucket_slots <= BSLOTS_W'(64);
      end else if (wr_en) begin
         if (reg_idx == REG_ITEM_SIZE) begin
            cfg_ff.item_size <= pwdata[ISIZE_W-1:0];
         end
         if (reg_idx == REG_ITEM_ALIGN) begin
            cfg_ff.item_align <= pwdata[IALIGN_W-1:0];
         end
         if (reg_idx == REG_BUCKET_SLOTS) begin
            cfg_ff.bucket_slots <= pwdata[BSLOTS_W-1:0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_ITEM_SIZE) begin
         prdata = APB_DW'(cfg_ff.item_size);
      end else if (reg_idx == REG_ITEM_ALIGN) begin
         prdata = APB_DW'(cfg_ff.item_align);
      end else if (reg_idx == REG_BUCKET_SLOTS) begin
         prdata = APB_DW'(cfg_ff.bucket_slots);
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/fspa_ctrl.sv =====
// transaction sequencer: accept, execute, stack read, respond
// depends on fspa_pkg
module fspa_ctrl
   import fspa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type dp_status,
   output ctrl_cmd_type  dp_cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (dp_status.pop) begin
                  state_ff <= S_READ;
               end else begin
                  state_ff     <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_READ: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff     <= S_IDLE;
                  rsp_valid_ff <= 1'b0;
               end
            end
            default: begin
               state_ff     <= S_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign dp_cmd.load    = (state_ff == S_IDLE) & req_valid;
   assign dp_cmd.exec    = (state_ff == S_EXEC);
   assign dp_cmd.capture = (state_ff == S_READ);

endmodule

// ===== src/fspa_dp.sv =====
// datapath: transaction registers, free stack memory, bucket counters, result
// depends on fspa_pkg
module fspa_dp
   import fspa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  ctrl_cmd_type        dp_cmd,
   output dp_status_type       dp_status,
   input  logic                req_cmd,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [RALIGN_W-1:0] req_align,
   input  logic [HANDLE_W-1:0] req_free_handle,
   input  logic                req_free_is_null,
   output logic [1:0]          rsp_status,
   output logic [HANDLE_W-1:0] rsp_handle
);

   // transaction registers
   logic                cmd_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [RALIGN_W-1:0] align_ff;
   logic [HANDLE_W-1:0] fh_ff;
   logic                null_ff;

   // counters
   logic [COUNT_W-1:0]  free_count_ff, free_count_in;
   logic [BKT_W-1:0]    buckets_ff, buckets_in;
   logic [SLOT_W-1:0]   slots_left_ff, slots_left_in;

   // result
   status_type          status_ff, status_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;

   // free stack
   logic [HANDLE_W-1:0] stack_mem [STACK_DEPTH];
   logic [HANDLE_W-1:0] rd_data_ff;
   logic [STACK_AW-1:0] rd_addr;
   logic                wr_en;

   // decision
   logic [ISIZE_W-1:0]  esize;
   logic [RALIGN_W-1:0] ealign;
   logic                reject;
   logic                pop;
   logic                push_ok;
   logic                full;
   logic [SLOT_W-1:0]   slots;
   logic                need_bucket;
   logic                no_bucket;
   logic [BKT_W-1:0]    bo_new;
   logic [SLOT_W-1:0]   sl_new;
   logic [SLOT_W-1:0]   idx;
   logic [MUL_W-1:0]    fresh_handle;

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff   <= req_cmd;
         size_ff  <= req_size;
         align_ff <= req_align;
         fh_ff    <= req_free_handle;
         null_ff  <= req_free_is_null;
      end
   end

   always_comb begin
      esize = cfg.item_size;
      if (ISIZE_W'(cfg.item_align) > esize) begin
         esize = ISIZE_W'(cfg.item_align);
      end
      if (esize < ISIZE_W'(MIN_SLOT_BYTES)) begin
         esize = ISIZE_W'(MIN_SLOT_BYTES);
      end
      ealign = (cfg.item_align != '0) ? RALIGN_W'(cfg.item_align)
                                      : derived_align(cfg.item_size);
   end

   assign reject  = (size_ff == '0) || (size_ff > SIZE_W'(esize)) || (align_ff > ealign);
   assign pop     = !cmd_ff && !reject && (free_count_ff != '0);
   assign push_ok = cmd_ff && !null_ff && (free_count_ff < COUNT_W'(STACK_DEPTH));
   assign full    = cmd_ff && !null_ff && (free_count_ff >= COUNT_W'(STACK_DEPTH));

   assign slots       = clamp_slots(cfg.bucket_slots);
   assign need_bucket = (slots_left_ff == '0);
   assign no_bucket   = need_bucket && (buckets_ff >= BKT_W'(MAX_BUCKETS));
   assign bo_new      = need_bucket ? buckets_ff + BKT_W'(1) : buckets_ff;
   assign sl_new      = need_bucket ? slots : slots_left_ff;
   assign idx         = (sl_new <= slots) ? slots - sl_new : '0;
   assign fresh_handle = MUL_W'(bo_new - BKT_W'(1)) * MUL_W'(slots) + MUL_W'(idx);

   always_comb begin
      free_count_in = free_count_ff;
      buckets_in    = buckets_ff;
      slots_left_in = slots_left_ff;
      status_in     = ST_OK;
      handle_in     = '0;
      if (cmd_ff) begin
         if (full) begin
            status_in = ST_STACK_FULL;
         end else if (push_ok) begin
            free_count_in = free_count_ff + COUNT_W'(1);
         end
      end else if (reject) begin
         status_in = ST_REJECT;
      end else if (pop) begin
         free_count_in = free_count_ff - COUNT_W'(1);
      end else if (no_bucket) begin
         status_in = ST_NO_BUCKET;
      end else begin
         buckets_in    = bo_new;
         slots_left_in = sl_new - SLOT_W'(1);
         handle_in     = fresh_handle[HANDLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= '0;
         buckets_ff    <= '0;
         slots_left_ff <= '0;
      end else if (dp_cmd.exec) begin
         free_count_ff <= free_count_in;
         buckets_ff    <= buckets_in;
         slots_left_ff <= slots_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.exec) begin
         status_ff <= status_in;
         handle_ff <= handle_in;
      end else if (dp_cmd.capture) begin
         handle_ff <= rd_data_ff;
      end
   end

   assign rd_addr = free_count_ff[STACK_AW-1:0] - STACK_AW'(1);
   assign wr_en   = dp_cmd.exec & push_ok;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stack_mem[free_count_ff[STACK_AW-1:0]] <= fh_ff;
      end
      rd_data_ff <= stack_mem[rd_addr];
   end

   assign dp_status.pop = pop;
   assign rsp_status    = status_ff;
   assign rsp_handle    = handle_ff;

endmodule

// ===== src/fixed_slot_pool_allocator.sv =====
// fixed slot pool allocator, top level
// a request steps through S_EXEC, S_READ when popping the free stack, and S_RESP with
// the result registered valid; the sequencer and the registered read of the free stack
// memory set the pace, no request is taken before the result leaves, and rsp_stall holds it
// reset is synchronous: settings go to defaults, sequencer and counters clear, stack kept
module fixed_slot_pool_allocator
   import fspa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_cmd,
   input  logic [SIZE_W-1:0]   req_size,
   input  logic [RALIGN_W-1:0] req_align,
   input  logic [HANDLE_W-1:0] req_free_handle,
   input  logic                req_free_is_null,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [HANDLE_W-1:0] rsp_handle,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [APB_AW-1:0]   paddr,
   input  logic [APB_DW-1:0]   pwdata,
   output logic [APB_DW-1:0]   prdata,
   output logic                pready
);

   cfg_type       cfg;
   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_status;

   fspa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fspa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   fspa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .dp_cmd           (dp_cmd),
      .dp_status        (dp_status),
      .req_cmd          (req_cmd),
      .req_size         (req_size),
      .req_align        (req_align),
      .req_free_handle  (req_free_handle),
      .req_free_is_null (req_free_is_null),
      .rsp_status       (rsp_status),
      .rsp_handle       (rsp_handle)
   );

`ifndef NO_ASSERTIONS
   // one transaction in flight: no new request taken while a result is pending
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a result is pending");

   // an accepted request never produces a result on the next edge
   a_no_early_rsp : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result appeared too early");

   // failed allocations and frees report a zero handle
   a_zero_handle : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_REJECT || rsp_status == ST_NO_BUCKET
                     || rsp_status == ST_STACK_FULL)) |-> (rsp_handle == '0))
      else $error("non-zero handle on a failed transaction");
`endif

endmodule
